/* rtl/core/emc_pkg.sv */
// Shared types and command codes for the extent map comparator.
package emc_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_COMPARE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CHK,
    S_LD_WR,
    S_SR_RD,
    S_SR_CHK,
    S_SR_FIN,
    S_CMP_RD,
    S_CMP_CHK,
    S_CMP_ADV,
    S_OUT
  } state_t;

endpackage

/* rtl/core/emc_ram.sv */
// Generic single-port RAM with registered read.
module emc_ram #(
  parameter int Width = 64,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/extent_map_compare.sv */
// Top level of the extent map comparator: two sorted extent tables and a range compare.
//
// Usage: one request on the in_ channel gives exactly one result on the out_ channel.
// A clear request empties the map chosen by in_map_sel. A load request appends,
// merges or drops an extent for that map and reports out_status. A compare request
// reports out_differs for the range in_query_offset / in_query_length.
// One request is worked on at a time; in_stall is high while busy or while a
// result waits. A compare does a binary search per map (up to log2(MAX_EXTENTS)+1
// halving steps each, then a check of the covering entry) and then walks the
// extents; each step goes through the single port of the extent table
// memories.
// The result is held in an output register until the receiver drops out_stall;
// no new request is taken until it is delivered.
// Reset clears both map counts; table contents are not cleared and only entries
// below a map's count are used.
module extent_map_compare #(
  parameter int MAX_EXTENTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic        in_map_sel,
  input  logic [63:0] in_ext_logical,
  input  logic [63:0] in_ext_physical,
  input  logic [63:0] in_ext_length,
  input  logic        in_ext_unknown,
  input  logic [63:0] in_query_offset,
  input  logic [63:0] in_query_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_differs,
  output logic [1:0]  out_status
);
  import emc_pkg::*;

  localparam int DEPTH = 2 * MAX_EXTENTS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic sel_r, sel_nxt;
  logic [63:0] lg_r, lg_nxt, ph_r, ph_nxt, ln_r, ln_nxt;
  logic [63:0] off_r, off_nxt, len_r, len_nxt;
  logic differs_r, differs_nxt;
  logic [1:0] status_r, status_nxt;
  // search bounds
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  // per-map walk index and validity; map select during search
  logic [CW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic va_r, va_nxt, vb_r, vb_nxt;
  logic side_r, side_nxt;
  // captured entry of map A during walk
  logic [63:0] a_st_r, a_st_nxt, a_pl_r, a_pl_nxt, a_sz_r, a_sz_nxt;

  logic we;
  logic [AW-1:0] addr;
  logic [63:0] wst, wpl, wsz, rst_d, rpl, rsz;

  emc_ram #(.Width(64), .Depth(DEPTH)) u_start (
    .clk(clk), .we(we), .addr(addr), .wdata(wst), .rdata(rst_d));
  emc_ram #(.Width(64), .Depth(DEPTH)) u_place (
    .clk(clk), .we(we), .addr(addr), .wdata(wpl), .rdata(rpl));
  emc_ram #(.Width(64), .Depth(DEPTH)) u_size (
    .clk(clk), .we(we), .addr(addr), .wdata(wsz), .rdata(rsz));

  function automatic logic [AW-1:0] mk_addr(input logic s, input logic [CW-1:0] i);
    logic [AW-1:0] base;
    base = s ? AW'(MAX_EXTENTS) : '0;
    return base + AW'(i[IW-1:0]);
  endfunction

  logic [CW-1:0] cnt_sel, mid;
  logic [63:0] aoff, boff, alen, blen, adv, off_adv;

  always_comb begin
    cnt_sel = sel_r ? cnt_b_r : cnt_a_r;
    mid = lo_r + ((hi_r - lo_r) >> 1);
    aoff = off_r - a_st_r;
    boff = off_r - rst_d;
    alen = a_sz_r - aoff;
    blen = rsz - boff;
    adv = len_r;
    if (adv > alen) adv = alen;
    if (adv > blen) adv = blen;
    off_adv = off_r + adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
    end
    sel_r <= sel_nxt; lg_r <= lg_nxt; ph_r <= ph_nxt; ln_r <= ln_nxt;
    off_r <= off_nxt; len_r <= len_nxt; differs_r <= differs_nxt;
    status_r <= status_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    ia_r <= ia_nxt; ib_r <= ib_nxt; va_r <= va_nxt; vb_r <= vb_nxt;
    side_r <= side_nxt; a_st_r <= a_st_nxt; a_pl_r <= a_pl_nxt; a_sz_r <= a_sz_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r; cnt_b_nxt = cnt_b_r;
    sel_nxt = sel_r; lg_nxt = lg_r; ph_nxt = ph_r; ln_nxt = ln_r;
    off_nxt = off_r; len_nxt = len_r; differs_nxt = differs_r;
    status_nxt = status_r; lo_nxt = lo_r; hi_nxt = hi_r;
    ia_nxt = ia_r; ib_nxt = ib_r; va_nxt = va_r; vb_nxt = vb_r;
    side_nxt = side_r; a_st_nxt = a_st_r; a_pl_nxt = a_pl_r; a_sz_nxt = a_sz_r;
    we = 1'b0;
    addr = '0;
    wst = lg_r; wpl = ph_r; wsz = ln_r;
    in_stall = 1'b1;
    out_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          sel_nxt = in_map_sel;
          lg_nxt = in_ext_logical; ph_nxt = in_ext_physical; ln_nxt = in_ext_length;
          off_nxt = in_query_offset; len_nxt = in_query_length;
          differs_nxt = 1'b0;
          status_nxt = ST_OK;
          state_nxt = S_OUT;
          case (cmd_t'(in_cmd))
            CMD_CLEAR: begin
              if (in_map_sel) cnt_b_nxt = '0;
              else cnt_a_nxt = '0;
            end
            CMD_LOAD: begin
              if (!in_ext_unknown) state_nxt = S_LD_RD;
            end
            CMD_COMPARE: begin
              if (in_query_length != 64'd0) begin
                side_nxt = 1'b0;
                lo_nxt = '0;
                hi_nxt = cnt_a_r;
                state_nxt = S_SR_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        addr = mk_addr(sel_r, cnt_sel - CW'(1));
        state_nxt = (cnt_sel == '0) ? S_LD_WR : S_LD_CHK;
      end
      S_LD_CHK: begin
        addr = mk_addr(sel_r, cnt_sel - CW'(1));
        if (rst_d + rsz == lg_r && rpl + rsz == ph_r) begin
          we = 1'b1;
          wst = rst_d; wpl = rpl; wsz = rsz + ln_r;
          state_nxt = S_OUT;
        end else if (lg_r <= rst_d) begin
          status_nxt = ST_ORDER;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LD_WR;
        end
      end
      S_LD_WR: begin
        addr = mk_addr(sel_r, cnt_sel);
        state_nxt = S_OUT;
        if (cnt_sel >= CW'(MAX_EXTENTS)) begin
          status_nxt = ST_FULL;
        end else begin
          we = 1'b1;
          if (sel_r) cnt_b_nxt = cnt_b_r + CW'(1);
          else cnt_a_nxt = cnt_a_r + CW'(1);
        end
      end
      S_SR_RD: begin
        if (lo_r < hi_r) begin
          addr = mk_addr(side_r, mid);
          state_nxt = S_SR_CHK;
        end else if (lo_r == '0) begin
          if (side_r) vb_nxt = 1'b0;
          else va_nxt = 1'b0;
          state_nxt = S_SR_FIN;
        end else begin
          addr = mk_addr(side_r, lo_r - CW'(1));
          state_nxt = S_SR_FIN;
        end
      end
      S_SR_CHK: begin
        if (rst_d <= off_r) lo_nxt = mid + CW'(1);
        else hi_nxt = mid;
        state_nxt = S_SR_RD;
      end
      S_SR_FIN: begin
        if (lo_r != '0) begin
          if (side_r) begin
            ib_nxt = lo_r - CW'(1);
            vb_nxt = !(off_r >= rst_d + rsz);
          end else begin
            ia_nxt = lo_r - CW'(1);
            va_nxt = !(off_r >= rst_d + rsz);
          end
        end
        if (!side_r) begin
          side_nxt = 1'b1;
          lo_nxt = '0;
          hi_nxt = cnt_b_r;
          state_nxt = S_SR_RD;
        end else begin
          state_nxt = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        if (len_r == 64'd0) begin
          state_nxt = S_OUT;
        end else if (!va_r || !vb_r) begin
          differs_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          addr = mk_addr(1'b0, ia_r);
          state_nxt = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        a_st_nxt = rst_d; a_pl_nxt = rpl; a_sz_nxt = rsz;
        addr = mk_addr(1'b1, ib_r);
        state_nxt = S_CMP_ADV;
      end
      S_CMP_ADV: begin
        if (off_r < a_st_r || off_r < rst_d || a_pl_r + aoff != rpl + boff) begin
          differs_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          off_nxt = off_adv;
          len_nxt = len_r - adv;
          if (adv == alen) begin
            ia_nxt = ia_r + CW'(1);
            va_nxt = (ia_r + CW'(1)) < cnt_a_r;
          end
          if (adv == blen) begin
            ib_nxt = ib_r + CW'(1);
            vb_nxt = (ib_r + CW'(1)) < cnt_b_r;
          end
          state_nxt = S_CMP_RD;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_differs = differs_r;
  assign out_status = status_r;
endmodule

/* verif/extent_map_compare_tb.sv */
// Testbench for extent_map_compare: directed table plus random map sequences vs. predictor.
`timescale 1ns / 100ps

module extent_map_compare_tb;
  import emc_pkg::*;

  localparam int NUM_EXT = 256;
  localparam int ITEMS = 900;
  localparam int QUIET_AT = 800;
  localparam int STALL_LIMIT = 8000;

  typedef struct {
    cmd_t        cmd;
    logic        sel;
    logic [63:0] lg;
    logic [63:0] ph;
    logic [63:0] ln;
    logic        unk;
    logic [63:0] qo;
    logic [63:0] ql;
  } ext_req_t;

  typedef struct {
    logic    differs;
    status_t status;
  } reply_t;

  typedef struct {
    ext_req_t req;
    logic     typed;
    logic     differs;
    status_t  status;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = 2'd0;
  logic        in_map_sel = 1'b0;
  logic [63:0] in_ext_logical = '0;
  logic [63:0] in_ext_physical = '0;
  logic [63:0] in_ext_length = '0;
  logic        in_ext_unknown = 1'b0;
  logic [63:0] in_query_offset = '0;
  logic [63:0] in_query_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_differs;
  logic [1:0]  out_status;

  logic [63:0] map_lo [2][NUM_EXT];
  logic [63:0] map_ph [2][NUM_EXT];
  logic [63:0] map_len [2][NUM_EXT];
  int          map_cnt [2];

  reply_t pending_replies[$];
  bit     failed = 0;
  bit     quiet = 0;
  int     sent = 0;
  int     idle_cycles = 0;
  int     stall_left = 0;

  extent_map_compare #(.MAX_EXTENTS(NUM_EXT)) dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int find_cover(input int sel, input logic [63:0] off);
    int lo;
    int hi;
    int mid;
    logic [63:0] stop;
    lo = 0;
    hi = map_cnt[sel];
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (map_lo[sel][mid] <= off) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return -1;
    lo = lo - 1;
    stop = map_lo[sel][lo] + map_len[sel][lo];
    if (off >= stop) return -1;
    return lo;
  endfunction

  function automatic logic range_differs(input logic [63:0] off, input logic [63:0] len);
    int ia;
    int ib;
    logic [63:0] aoff, boff, alen, blen, adv, ea, eb, pa, pb;
    ia = find_cover(0, off);
    ib = find_cover(1, off);
    while (len != 0) begin
      if (ia < 0 || ib < 0) return 1'b1;
      if (off < map_lo[0][ia] || off < map_lo[1][ib]) return 1'b1;
      aoff = off - map_lo[0][ia];
      boff = off - map_lo[1][ib];
      pa = map_ph[0][ia] + aoff;
      pb = map_ph[1][ib] + boff;
      if (pa != pb) return 1'b1;
      alen = map_len[0][ia] - aoff;
      blen = map_len[1][ib] - boff;
      adv = len;
      if (adv > alen) adv = alen;
      if (adv > blen) adv = blen;
      off = off + adv;
      ea = map_lo[0][ia] + map_len[0][ia];
      eb = map_lo[1][ib] + map_len[1][ib];
      if (off == ea) ia = (ia + 1 < map_cnt[0]) ? ia + 1 : -1;
      if (off == eb) ib = (ib + 1 < map_cnt[1]) ? ib + 1 : -1;
      len = len - adv;
    end
    return 1'b0;
  endfunction

  function automatic status_t append_extent(input int sel, input logic [63:0] lg,
                                            input logic [63:0] ph, input logic [63:0] ln);
    int last;
    logic [63:0] lend, pend;
    if (map_cnt[sel] > 0) begin
      last = map_cnt[sel] - 1;
      lend = map_lo[sel][last] + map_len[sel][last];
      pend = map_ph[sel][last] + map_len[sel][last];
      if (lend == lg && pend == ph) begin
        map_len[sel][last] = map_len[sel][last] + ln;
        return ST_OK;
      end
      if (lg <= map_lo[sel][last]) return ST_ORDER;
    end
    if (map_cnt[sel] >= NUM_EXT) return ST_FULL;
    map_lo[sel][map_cnt[sel]] = lg;
    map_ph[sel][map_cnt[sel]] = ph;
    map_len[sel][map_cnt[sel]] = ln;
    map_cnt[sel]++;
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(input ext_req_t r);
    reply_t e;
    e.differs = 1'b0;
    e.status = ST_OK;
    case (r.cmd)
      CMD_CLEAR: map_cnt[r.sel] = 0;
      CMD_LOAD: if (!r.unk) e.status = append_extent(r.sel, r.lg, r.ph, r.ln);
      CMD_COMPARE: e.differs = range_differs(r.qo, r.ql);
      default: ;
    endcase
    return e;
  endfunction

  task automatic send_req(input ext_req_t r, input logic typed = 1'b0,
                          input logic t_diff = 1'b0, input status_t t_stat = ST_OK);
    int gap;
    reply_t e;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_cmd <= r.cmd;
    in_map_sel <= r.sel;
    in_ext_logical <= r.lg;
    in_ext_physical <= r.ph;
    in_ext_length <= r.ln;
    in_ext_unknown <= r.unk;
    in_query_offset <= r.qo;
    in_query_length <= r.ql;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    e = predict_reply(r);
    if (typed) begin
      e.differs = t_diff;
      e.status = t_stat;
    end
    pending_replies.push_back(e);
    sent++;
  endtask

  function automatic ext_req_t mk(input cmd_t c, input logic s, input logic [63:0] lg,
                                  input logic [63:0] ph, input logic [63:0] ln,
                                  input logic u, input logic [63:0] qo,
                                  input logic [63:0] ql);
    ext_req_t r;
    r.cmd = c; r.sel = s; r.lg = lg; r.ph = ph; r.ln = ln; r.unk = u; r.qo = qo; r.ql = ql;
    return r;
  endfunction

  task automatic send_load(input logic s, input logic [63:0] lg, input logic [63:0] ph,
                           input logic [63:0] ln, input logic u = 1'b0);
    send_req(mk(CMD_LOAD, s, lg, ph, ln, u, rand64(), rand64()));
  endtask

  task automatic send_compare(input logic [63:0] qo, input logic [63:0] ql);
    send_req(mk(CMD_COMPARE, $urandom_range(0, 1), rand64(), rand64(), rand64(),
                $urandom_range(0, 1), qo, ql));
  endtask

  task automatic send_clear(input logic s);
    send_req(mk(CMD_CLEAR, s, rand64(), rand64(), rand64(), $urandom_range(0, 1),
                rand64(), rand64()));
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic run_noise(input int n);
    ext_req_t r;
    for (int i = 0; i < n; i++) begin
      r = mk(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1), rand64(), rand64(),
             rand64(), $urandom_range(0, 1), rand64(), rand64());
      send_req(r);
    end
  endtask

  task automatic run_matched();
    logic [63:0] xl[$], xp[$], xn[$];
    logic [63:0] cur, piece, lg, ph, left, qo, ql;
    int n, bad, bad_kind, k, j;
    cur = ($urandom_range(0, 5) == 0) ? {32'hFFFF_FFFF, $urandom} :
                                        {24'h0, $urandom_range(0, 255), $urandom};
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      cur = cur + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40));
      xl.push_back(cur);
      xp.push_back(rand64());
      xn.push_back($urandom_range(1, 300));
      cur = cur + xn[i];
    end
    bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
    bad_kind = $urandom_range(0, 1);
    if ($urandom_range(0, 1)) begin
      send_clear(1'b0); send_clear(1'b1);
    end else begin
      send_clear(1'b1); send_clear(1'b0);
    end
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) send_load(s, rand64(), rand64(), rand64(), 1'b1);
        if (i > 0 && $urandom_range(0, 9) == 0) send_load(s, xl[0], rand64(), rand64());
        if (s == 1 && i == bad && bad_kind == 0) continue;
        lg = xl[i];
        ph = xp[i] + ((s == 1 && i == bad) ? 64'd1 : 64'd0);
        left = xn[i];
        k = $urandom_range(1, 3);
        for (j = 1; j < k && left > 1; j++) begin
          piece = $urandom_range(1, left - 1);
          send_load(s, lg, ph, piece);
          lg = lg + piece; ph = ph + piece; left = left - piece;
        end
        send_load(s, lg, ph, left);
      end
    end
    k = $urandom_range(3, 8);
    for (int i = 0; i < k; i++) begin
      j = $urandom_range(0, n - 1);
      qo = xl[j] + $urandom_range(0, xn[j]) - (($urandom_range(0, 4) == 0) ? 3 : 0);
      case ($urandom_range(0, 4))
        0: ql = 0;
        1: ql = 1;
        2: ql = rand64();
        default: ql = $urandom_range(1, 2000);
      endcase
      send_compare(qo, ql);
    end
  endtask

  task automatic run_fill(input logic s);
    logic [63:0] ph;
    send_clear(s);
    for (int i = 0; i < NUM_EXT + 3; i++) begin
      ph = rand64();
      if (i == NUM_EXT - 1) send_load(s, 64'(i) * 16, 64'h1000, 8);
      else send_load(s, 64'(i) * 16, ph, 8);
    end
    send_load(s, 64'(NUM_EXT - 1) * 16 + 8, 64'h1008, 4);
    send_compare(0, 64'(NUM_EXT) * 16);
    send_compare(64'd40, 64'd3);
    send_compare(rand64(), rand64());
  endtask

  table_row_t steps[] = '{
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 0, 5), 1, 1, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_NONE, 1, '1, '1, '1, 1, '1, '1), 1, 0, ST_OK},
    '{mk(CMD_LOAD, 0, 100, 1000, 50, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_LOAD, 0, 5, 7, 9, 1, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_LOAD, 0, 150, 1050, 25, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_LOAD, 0, 100, 7, 3, 0, 0, 0), 1, 0, ST_ORDER},
    '{mk(CMD_LOAD, 0, 50, 7, 3, 0, 0, 0), 1, 0, ST_ORDER},
    '{mk(CMD_LOAD, 1, 100, 1000, 30, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_LOAD, 1, 130, 1030, 45, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 100, 75), 0, 0, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 90, 20), 0, 0, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 174, 2), 0, 0, ST_OK},
    '{mk(CMD_LOAD, 1, 200, 5000, 10, 0, 0, 0), 0, 0, ST_OK},
    '{mk(CMD_LOAD, 0, 200, 5001, 10, 0, 0, 0), 0, 0, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 195, 10), 0, 0, ST_OK},
    '{mk(CMD_LOAD, 0, 64'hFFFF_FFFF_FFFF_FFF0, '1, 64'h20, 0, 0, 0), 0, 0, ST_OK},
    '{mk(CMD_LOAD, 1, 64'hFFFF_FFFF_FFFF_FFF0, '1, 64'h20, 0, 0, 0), 0, 0, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF8, 64'h10), 0, 0, ST_OK},
    '{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, 100, 1), 1, 1, ST_OK},
    '{mk(CMD_CLEAR, 1, 0, 0, 0, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_LOAD, 0, '1, 0, '1, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_LOAD, 1, '1, 0, '1, 0, 0, 0), 1, 0, ST_OK},
    '{mk(CMD_COMPARE, 0, 0, 0, 0, 0, '1, '1), 0, 0, ST_OK}
  };

  initial begin
    bit filled;
    map_cnt[0] = 0;
    map_cnt[1] = 0;
    filled = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (steps[i])
      send_req(steps[i].req, steps[i].typed, steps[i].differs, steps[i].status);
    hold_until_drained();
    while (sent < ITEMS) begin
      quiet = (sent >= QUIET_AT);
      if (!filled && sent > 250) begin
        run_fill($urandom_range(0, 1));
        filled = 1;
      end else begin
        case ($urandom_range(0, 9))
          7, 8: run_noise($urandom_range(3, 6));
          9: hold_until_drained();
          default: run_matched();
        endcase
      end
    end
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    reply_t e;
    if (out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply differs=%0d status=%0d", $time, out_differs,
                 out_status);
        failed = 1;
      end else begin
        e = pending_replies.pop_front();
        if (out_differs !== e.differs) begin
          $display("%0t: differs expected %0d actual %0d", $time, e.differs, out_differs);
          failed = 1;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          failed = 1;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Regression FAIL");
      $finish;
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

endmodule
